>>> src/bom_pkg.sv
`default_nettype none
package bom_pkg;

  localparam int MAX_BOXES_DEF  = 16;
  localparam int COORD_BITS_DEF = 12;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_ILOOP,
    S_READ,
    S_CMP,
    S_SHRD,
    S_SHWR,
    S_OUTRD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_list;
    logic round_init;
    logic pass_next;
    logic j_clr;
    logic i_inc;
    logic j_inc;
    logic hit;
    logic sh_rd;
    logic sh_wr;
    logic cnt_dec;
    logic out_rd;
    logic out_emit;
  } cmd_t;

  typedef struct packed {
    logic i_lt_cnt;
    logic j_lt_cnt;
    logic pass;
    logic changed;
    logic cond;
    logic sh_more;
    logic k_last;
  } status_t;

endpackage
`default_nettype wire

>>> src/bom_ram.sv
`default_nettype none
module bom_ram #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> src/bom_ctrl.sv
`default_nettype none
module bom_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              is_final,
  input  wire bom_pkg::status_t  st,
  output logic                   busy,
  output bom_pkg::cmd_t          cmd
);

  bom_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bom_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bom_pkg::S_IDLE: begin
        if (start && is_final) state_nxt = bom_pkg::S_ROUND;
      end
      bom_pkg::S_ROUND: state_nxt = bom_pkg::S_ILOOP;
      bom_pkg::S_ILOOP: begin
        if (st.i_lt_cnt) state_nxt = bom_pkg::S_READ;
        else if (!st.pass) state_nxt = bom_pkg::S_ILOOP;
        else if (st.changed) state_nxt = bom_pkg::S_ROUND;
        else state_nxt = bom_pkg::S_OUTRD;
      end
      bom_pkg::S_READ: begin
        state_nxt = st.j_lt_cnt ? bom_pkg::S_CMP : bom_pkg::S_ILOOP;
      end
      bom_pkg::S_CMP: begin
        state_nxt = st.cond ? bom_pkg::S_SHRD : bom_pkg::S_READ;
      end
      bom_pkg::S_SHRD: begin
        state_nxt = st.sh_more ? bom_pkg::S_SHWR : bom_pkg::S_READ;
      end
      bom_pkg::S_SHWR:  state_nxt = bom_pkg::S_SHRD;
      bom_pkg::S_OUTRD: state_nxt = bom_pkg::S_OUT;
      bom_pkg::S_OUT: begin
        state_nxt = st.k_last ? bom_pkg::S_IDLE : bom_pkg::S_OUTRD;
      end
      default: state_nxt = bom_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != bom_pkg::S_IDLE);
    case (state_r)
      bom_pkg::S_IDLE:  cmd.load = start;
      bom_pkg::S_ROUND: cmd.round_init = 1'b1;
      bom_pkg::S_ILOOP: begin
        if (st.i_lt_cnt) cmd.j_clr = 1'b1;
        else if (!st.pass) cmd.pass_next = 1'b1;
      end
      bom_pkg::S_READ: begin
        if (!st.j_lt_cnt) cmd.i_inc = 1'b1;
      end
      bom_pkg::S_CMP: begin
        if (st.cond) cmd.hit = 1'b1;
        else cmd.j_inc = 1'b1;
      end
      bom_pkg::S_SHRD: begin
        if (st.sh_more) cmd.sh_rd = 1'b1;
        else cmd.cnt_dec = 1'b1;
      end
      bom_pkg::S_SHWR:  cmd.sh_wr = 1'b1;
      bom_pkg::S_OUTRD: cmd.out_rd = 1'b1;
      bom_pkg::S_OUT: begin
        cmd.out_emit = 1'b1;
        cmd.clr_list = st.k_last;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/bom_dp.sv
`default_nettype none
module bom_dp #(
  parameter int MAX_BOXES  = bom_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = bom_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bom_pkg::cmd_t         cmd,
  output bom_pkg::status_t           st,
  input  wire logic [COORD_BITS-1:0] in_x,
  input  wire logic [COORD_BITS-1:0] in_y,
  input  wire logic [COORD_BITS-1:0] in_w,
  input  wire logic [COORD_BITS-1:0] in_h,
  output logic      [COORD_BITS-1:0] o_x,
  output logic      [COORD_BITS-1:0] o_y,
  output logic      [COORD_BITS:0]   o_w,
  output logic      [COORD_BITS:0]   o_h,
  output logic                       o_final,
  output logic                       o_dropped
);

  localparam int CW  = COORD_BITS;
  localparam int SW  = COORD_BITS + 1;
  localparam int XW  = COORD_BITS + 2;
  localparam int EW  = 2 * CW + 2 * SW;
  localparam int IW  = $clog2(MAX_BOXES);
  localparam int NW  = $clog2(MAX_BOXES + 1);
  localparam logic [NW-1:0] MAXN = NW'(MAX_BOXES);

  logic [NW-1:0] cnt_r, i_r, j_r, m_r, k_r;
  logic          ovf_r, pass_r, chg_r;

  logic          we;
  logic [IW-1:0] waddr, raddr_a, raddr_b;
  logic [EW-1:0] wdata, rd_a, rd_b;

  logic [CW-1:0] ax, ay, bx, by;
  logic [SW-1:0] aw, ah, bw, bh;
  logic [XW-1:0] ar, ab, br, bb;
  logic [CW-1:0] ul, ut;
  logic [XW-1:0] ur, ud;
  logic [SW-1:0] uw, uh;
  logic          holds, crosses;

  assign ax = rd_a[EW-1 -: CW];
  assign ay = rd_a[EW-1-CW -: CW];
  assign aw = rd_a[2*SW-1 -: SW];
  assign ah = rd_a[SW-1:0];
  assign bx = rd_b[EW-1 -: CW];
  assign by = rd_b[EW-1-CW -: CW];
  assign bw = rd_b[2*SW-1 -: SW];
  assign bh = rd_b[SW-1:0];

  assign ar = {2'b00, ax} + {1'b0, aw};
  assign ab = {2'b00, ay} + {1'b0, ah};
  assign br = {2'b00, bx} + {1'b0, bw};
  assign bb = {2'b00, by} + {1'b0, bh};

  assign holds   = (ax <= bx) && (br <= ar) && (ay <= by) && (bb <= ab);
  assign crosses = ({2'b00, bx} < ar) && (br > {2'b00, ax}) &&
                   ({2'b00, by} < ab) && (bb > {2'b00, ay});

  assign ul = (ax < bx) ? ax : bx;
  assign ut = (ay < by) ? ay : by;
  assign ur = (ar > br) ? ar : br;
  assign ud = (ab > bb) ? ab : bb;
  assign uw = SW'(ur - {2'b00, ul});
  assign uh = SW'(ud - {2'b00, ut});

  always_comb begin
    we    = 1'b0;
    waddr = cnt_r[IW-1:0];
    wdata = {in_x, in_y, 1'b0, in_w, 1'b0, in_h};
    if (cmd.load) begin
      we = (cnt_r < MAXN);
    end else if (cmd.hit) begin
      we    = pass_r;
      waddr = i_r[IW-1:0];
      wdata = {ul, ut, uw, uh};
    end else if (cmd.sh_wr) begin
      we    = 1'b1;
      waddr = m_r[IW-1:0];
      wdata = rd_a;
    end
  end

  always_comb begin
    logic [NW-1:0] m1;
    m1 = m_r + NW'(1);
    if (cmd.sh_rd) raddr_a = m1[IW-1:0];
    else if (cmd.out_rd) raddr_a = k_r[IW-1:0];
    else raddr_a = i_r[IW-1:0];
    raddr_b = j_r[IW-1:0];
  end

  bom_ram #(.WIDTH(EW), .DEPTH(MAX_BOXES)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      pass_r <= 1'b0;
      chg_r  <= 1'b0;
      i_r    <= '0;
      j_r    <= '0;
      m_r    <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.load) begin
        if (cnt_r < MAXN) cnt_r <= cnt_r + NW'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.round_init) begin
        chg_r  <= 1'b0;
        pass_r <= 1'b0;
        i_r    <= '0;
        k_r    <= '0;
      end
      if (cmd.pass_next) begin
        pass_r <= 1'b1;
        i_r    <= '0;
      end
      if (cmd.j_clr) j_r <= '0;
      if (cmd.i_inc) i_r <= i_r + NW'(1);
      if (cmd.j_inc) j_r <= j_r + NW'(1);
      if (cmd.hit) begin
        chg_r <= 1'b1;
        m_r   <= j_r;
        if (j_r < i_r) i_r <= i_r - NW'(1);
      end
      if (cmd.sh_wr) m_r <= m_r + NW'(1);
      if (cmd.cnt_dec) cnt_r <= cnt_r - NW'(1);
      if (cmd.out_emit) k_r <= cmd.clr_list ? '0 : k_r + NW'(1);
      if (cmd.clr_list) begin
        cnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

  always_comb begin
    st.i_lt_cnt = (i_r < cnt_r);
    st.j_lt_cnt = (j_r < cnt_r);
    st.pass     = pass_r;
    st.changed  = chg_r;
    st.cond     = (i_r != j_r) && (pass_r ? crosses : holds);
    st.sh_more  = ((m_r + NW'(1)) < cnt_r);
    st.k_last   = ((k_r + NW'(1)) == cnt_r);
  end

  assign o_x       = ax;
  assign o_y       = ay;
  assign o_w       = aw;
  assign o_h       = ah;
  assign o_final   = st.k_last;
  assign o_dropped = ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= MAXN)
    else $error("box count above capacity");
  a_hit_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hit |-> (i_r != j_r) && (j_r < cnt_r) && (i_r < cnt_r))
    else $error("pair hit on bad indexes");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_emit |-> (cnt_r != '0) && (k_r < cnt_r))
    else $error("emit beyond list");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_list |=> (cnt_r == '0) && !ovf_r)
    else $error("list not cleared after output");

endmodule
`default_nettype wire

>>> src/box_overlap_merger_top.sv
// Channel   Handshake              Ports
// input     start & !busy          in_box_x in_box_y in_box_w in_box_h in_is_final
// result    out_valid (1 cycle)    out_x out_y out_w out_h out_final out_dropped
//
// An item, the final one too, is stored unless the list is full, which sets the
// dropped flag. After the final item each round initialises, then makes two passes
// testing each pair, merging on a hit and moving entries after a removed one down;
// repeat until no change. Results then leave; busy stays high until the last one.
// Reset (rst_n low, synchronous) empties the list and clears the dropped flag.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none
module box_overlap_merger_top #(
  parameter int MAX_BOXES  = bom_pkg::MAX_BOXES_DEF,
  parameter int COORD_BITS = bom_pkg::COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] in_box_x,
  input  wire logic [COORD_BITS-1:0] in_box_y,
  input  wire logic [COORD_BITS-1:0] in_box_w,
  input  wire logic [COORD_BITS-1:0] in_box_h,
  input  wire logic                  in_is_final,
  output logic                       out_valid,
  output logic      [COORD_BITS-1:0] out_x,
  output logic      [COORD_BITS-1:0] out_y,
  output logic      [COORD_BITS:0]   out_w,
  output logic      [COORD_BITS:0]   out_h,
  output logic                       out_final,
  output logic                       out_dropped
);

  bom_pkg::cmd_t    cmd;
  bom_pkg::status_t st;

  bom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .is_final (in_is_final),
    .st       (st),
    .busy     (busy),
    .cmd      (cmd)
  );

  bom_dp #(.MAX_BOXES(MAX_BOXES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_x      (in_box_x),
    .in_y      (in_box_y),
    .in_w      (in_box_w),
    .in_h      (in_box_h),
    .o_x       (out_x),
    .o_y       (out_y),
    .o_w       (out_w),
    .o_h       (out_h),
    .o_final   (out_final),
    .o_dropped (out_dropped)
  );

  assign out_valid = cmd.out_emit;

endmodule
`default_nettype wire
